// ----- design/acsp_pkg.sv -----
// ----------------------------------------------------------------------------
// acsp_pkg
// Types, codes and small helpers for the ASCII axis command stream parser.
// ----------------------------------------------------------------------------
package acsp_pkg;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_STOP,
        PH_IDX,
        PH_POS,
        PH_NUM_SI,
        PH_EASE,
        PH_NUM_G,
        PH_DONE,
        PH_BAD
    } t_phase;

    localparam logic [1:0] KIND_AXIS = 2'd0;
    localparam logic [1:0] KIND_EXEC = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    localparam logic [1:0] IK_SHORT    = 2'd0;
    localparam logic [1:0] IK_SPEED    = 2'd1;
    localparam logic [1:0] IK_INTERVAL = 2'd2;

    localparam logic [2:0] ST_RAMPED   = 3'd0;
    localparam logic [2:0] ST_EASE_IN  = 3'd1;
    localparam logic [2:0] ST_EASE_OUT = 3'd2;
    localparam logic [2:0] ST_EASE_BOTH = 3'd3;
    localparam logic [2:0] ST_GRADIENT = 3'd4;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

    function automatic logic f_is_digit(input logic [7:0] c);
        f_is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] f_upper(input logic [7:0] c);
        f_upper = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
    endfunction

    function automatic logic f_is_ws(input logic [7:0] c);
        f_is_ws = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // one decimal digit into a magnitude that saturates at 2^31
    function automatic logic [31:0] f_mag_step(input logic [31:0] m, input logic [7:0] c);
        logic [35:0] t;
        t = {4'd0, m} * 36'd10 + {32'd0, c[3:0]};
        f_mag_step = (t > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : t[31:0];
    endfunction

    // "DSTOP" by position
    function automatic logic [7:0] f_stop_char(input logic [2:0] p);
        logic [7:0] r;
        r = 8'h00;
        unique case (p)
            3'd0: r = 8'h44;
            3'd1: r = 8'h53;
            3'd2: r = 8'h54;
            3'd3: r = 8'h4F;
            3'd4: r = 8'h50;
            default: r = 8'h00;
        endcase
        f_stop_char = r;
    endfunction

endpackage

// ----- design/axis_command_stream_parser.sv -----
// ----------------------------------------------------------------------------
// axis_command_stream_parser
// Parses an ASCII byte stream into axis move, execute-all and stop-all words.
// ----------------------------------------------------------------------------
// channel   | dir | handshake                 | payload
// s_axis    | in  | i_s_axis_tvalid/o_tready  | tdata: in_byte
// m_axis    | out | o_m_axis_tvalid/i_tready  | tuser: kind; tdata: axis fields; tlast
// cfg       | in  | i_cfg_valid/o_cfg_ready   | i_cfg_data: registered_axes
//
// One byte per cycle unless the output stalls; the token is parsed as it arrives,
// one state update per byte. A delimiter that yields two words (axis move, then
// execute all) holds the input until the axis move word is taken and the second word is shown.
// Synchronous active-low reset clears the token and the output stage.
// A stalled output holds its word and the input is taken again once it drains.
// ----------------------------------------------------------------------------
module axis_command_stream_parser #(
    parameter int TOKEN_MAX     = 47,
    parameter int AXES_PER_BANK = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,   // bank, index, position, input_kind,
                                          // ext_param, move_style, gradient
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [39:0] i_cfg_data
);

    localparam int LW = $clog2(TOKEN_MAX + 1);

    logic [39:0]          r_axes;
    logic [LW-1:0]        r_len,   n_len;
    logic                 r_dead,  n_dead;
    acsp_pkg::t_phase     r_phase, n_phase;
    logic [1:0]           r_bank,  n_bank;
    logic [3:0]           r_idx,   n_idx;
    logic [13:0]          r_pos,   n_pos;
    logic [2:0]           r_pcnt,  n_pcnt;
    logic                 r_letter, n_letter;
    logic [1:0]           r_ik,    n_ik;
    logic [31:0]          r_pacc,  n_pacc;
    logic [31:0]          r_gacc,  n_gacc;
    logic                 r_sgn,   n_sgn;
    logic                 r_neg,   n_neg;
    logic                 r_dig,   n_dig;
    logic                 r_ein,   n_ein;
    logic                 r_eout,  n_eout;
    logic                 r_hasg,  n_hasg;
    logic [2:0]           r_sp,    n_sp;

    logic                 r_ovalid;
    logic                 r_pend;
    logic [87:0]          r_odata;
    logic [1:0]           r_okind;
    logic                 r_olast;

    logic       in_fire, out_fire, is_delim, is_exec, tok_end, append;
    logic [7:0] b, bu;
    logic [31:0] cur_acc, acc_step;
    logic [13:0] weight;
    logic [5:0]  bit_idx;
    logic        axis_ok, stop_ok, si_ok, hasg_f;
    logic [1:0]  ik_f;
    logic [30:0] ext_f;
    logic [2:0]  style_f;
    logic [31:0] grad_f;
    logic [87:0] axis_data;

    assign b        = i_s_axis_tdata;
    assign bu       = acsp_pkg::f_upper(b);
    assign is_delim = (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D);
    assign is_exec  = is_delim && (b != 8'h20);
    assign o_s_axis_tready = !r_ovalid || (i_m_axis_tready && !r_pend);
    assign o_cfg_ready = 1'b1;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = r_ovalid && i_m_axis_tready;
    assign tok_end  = in_fire && is_delim && (r_len != '0);
    assign append   = in_fire && !is_delim && (r_len < LW'(TOKEN_MAX));

    assign cur_acc  = (r_phase == acsp_pkg::PH_NUM_G) ? r_gacc : r_pacc;
    assign acc_step = acsp_pkg::f_mag_step(cur_acc, b);

    always_comb begin
        unique case (r_pcnt[1:0])
            2'd0: weight = 14'd1000;
            2'd1: weight = 14'd100;
            2'd2: weight = 14'd10;
            default: weight = 14'd1;
        endcase
    end

    // next token state
    always_comb begin
        n_len = r_len; n_dead = r_dead; n_phase = r_phase; n_bank = r_bank;
        n_idx = r_idx; n_pos = r_pos; n_pcnt = r_pcnt; n_letter = r_letter;
        n_ik = r_ik; n_pacc = r_pacc; n_gacc = r_gacc; n_sgn = r_sgn;
        n_neg = r_neg; n_dig = r_dig; n_ein = r_ein; n_eout = r_eout;
        n_hasg = r_hasg; n_sp = r_sp;
        if (in_fire && is_delim) begin
            n_len = '0; n_dead = 1'b0; n_phase = acsp_pkg::PH_FIRST;
            n_bank = '0; n_idx = '0; n_pos = '0; n_pcnt = '0; n_letter = 1'b0;
            n_ik = acsp_pkg::IK_SHORT; n_pacc = '0; n_gacc = '0; n_sgn = 1'b0;
            n_neg = 1'b0; n_dig = 1'b0; n_ein = 1'b0; n_eout = 1'b0;
            n_hasg = 1'b0; n_sp = '0;
        end else if (append) begin
            n_len = r_len + LW'(1);
            if (r_dead || b == 8'h00) begin
                n_dead = 1'b1;
            end else begin
                unique case (r_phase)
                    acsp_pkg::PH_FIRST: begin
                        if (b == 8'h44) begin
                            n_phase = acsp_pkg::PH_STOP;
                            n_sp = 3'd1;
                        end else if (bu == 8'h4C) begin
                            n_bank = 2'd0; n_phase = acsp_pkg::PH_IDX;
                        end else if (bu == 8'h52) begin
                            n_bank = 2'd1; n_phase = acsp_pkg::PH_IDX;
                        end else if (bu == 8'h56) begin
                            n_bank = 2'd2; n_phase = acsp_pkg::PH_IDX;
                        end else if (bu == 8'h41) begin
                            n_bank = 2'd3; n_phase = acsp_pkg::PH_IDX;
                        end else begin
                            n_phase = acsp_pkg::PH_BAD;
                        end
                    end
                    acsp_pkg::PH_STOP: begin
                        if (r_sp < 3'd5 && b == acsp_pkg::f_stop_char(r_sp)) begin
                            n_sp = r_sp + 3'd1;
                        end else begin
                            n_phase = acsp_pkg::PH_BAD;
                        end
                    end
                    acsp_pkg::PH_IDX: begin
                        if (acsp_pkg::f_is_digit(b) && ({28'd0, b[3:0]} < AXES_PER_BANK)) begin
                            n_idx = b[3:0]; n_phase = acsp_pkg::PH_POS;
                        end else begin
                            n_phase = acsp_pkg::PH_BAD;
                        end
                    end
                    acsp_pkg::PH_POS: begin
                        if (r_pcnt < 3'd4 && acsp_pkg::f_is_digit(b)) begin
                            n_pos = r_pos + 14'(weight * {10'd0, b[3:0]});
                            n_pcnt = r_pcnt + 3'd1;
                        end else if (r_pcnt == 3'd0) begin
                            n_phase = acsp_pkg::PH_BAD;
                        end else if (bu == 8'h53 || bu == 8'h49) begin
                            n_letter = (bu == 8'h49);
                            n_phase = acsp_pkg::PH_NUM_SI;
                        end else begin
                            n_phase = acsp_pkg::PH_EASE;
                            if (b == 8'h3C) n_ein = 1'b1;
                            if (b == 8'h3E) n_eout = 1'b1;
                            if (bu == 8'h47) n_phase = acsp_pkg::PH_NUM_G;
                        end
                    end
                    acsp_pkg::PH_NUM_SI, acsp_pkg::PH_NUM_G: begin
                        if (acsp_pkg::f_is_digit(b)) begin
                            n_dig = 1'b1;
                            if (r_phase == acsp_pkg::PH_NUM_G) n_gacc = acc_step;
                            else n_pacc = acc_step;
                        end else if (!r_dig && !r_sgn && acsp_pkg::f_is_ws(b)) begin
                            n_dig = 1'b0;
                        end else if (!r_dig && !r_sgn && (b == 8'h2B || b == 8'h2D)) begin
                            n_sgn = 1'b1; n_neg = (b == 8'h2D);
                        end else if (r_phase == acsp_pkg::PH_NUM_G) begin
                            n_hasg = r_dig; n_phase = acsp_pkg::PH_DONE;
                        end else if (si_ok) begin
                            n_ik = r_letter ? acsp_pkg::IK_INTERVAL : acsp_pkg::IK_SPEED;
                            n_sgn = 1'b0; n_neg = 1'b0; n_dig = 1'b0;
                            n_phase = acsp_pkg::PH_EASE;
                            if (b == 8'h3C) n_ein = 1'b1;
                            if (b == 8'h3E) n_eout = 1'b1;
                            if (bu == 8'h47) n_phase = acsp_pkg::PH_NUM_G;
                        end else begin
                            n_ik = acsp_pkg::IK_SHORT; n_phase = acsp_pkg::PH_DONE;
                        end
                    end
                    acsp_pkg::PH_EASE: begin
                        if (b == 8'h3C) n_ein = 1'b1;
                        if (b == 8'h3E) n_eout = 1'b1;
                        if (bu == 8'h47) n_phase = acsp_pkg::PH_NUM_G;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // token result
    always_comb begin
        si_ok   = r_dig && !r_neg && (r_pacc != '0);
        bit_idx = 6'({4'd0, r_bank} * 6'd10 + {2'd0, r_idx});
        if (r_phase == acsp_pkg::PH_NUM_SI) begin
            ik_f = si_ok ? (r_letter ? acsp_pkg::IK_INTERVAL : acsp_pkg::IK_SPEED)
                         : acsp_pkg::IK_SHORT;
        end else begin
            ik_f = r_ik;
        end
        hasg_f = r_hasg || (r_phase == acsp_pkg::PH_NUM_G && r_dig);
        axis_ok = (r_phase == acsp_pkg::PH_POS || r_phase == acsp_pkg::PH_NUM_SI ||
                   r_phase == acsp_pkg::PH_EASE || r_phase == acsp_pkg::PH_NUM_G ||
                   r_phase == acsp_pkg::PH_DONE) && (r_pcnt != 3'd0) && r_axes[bit_idx];
        stop_ok = (r_phase == acsp_pkg::PH_STOP) && (r_sp == 3'd5);
        ext_f = '0;
        if (ik_f != acsp_pkg::IK_SHORT) begin
            ext_f = r_pacc[31] ? 31'h7FFF_FFFF : r_pacc[30:0];
        end
        if (r_neg) grad_f = r_gacc[31] ? 32'h8000_0000 : (32'd0 - r_gacc);
        else       grad_f = r_gacc[31] ? 32'h7FFF_FFFF : r_gacc;
        priority if (ik_f == acsp_pkg::IK_SHORT) begin
            style_f = acsp_pkg::ST_RAMPED; grad_f = '0;
        end else if (hasg_f) begin
            style_f = acsp_pkg::ST_GRADIENT;
        end else if (r_ein && r_eout) begin
            style_f = acsp_pkg::ST_EASE_BOTH; grad_f = '0;
        end else if (r_ein) begin
            style_f = acsp_pkg::ST_EASE_IN; grad_f = '0;
        end else if (r_eout) begin
            style_f = acsp_pkg::ST_EASE_OUT; grad_f = '0;
        end else begin
            style_f = acsp_pkg::ST_RAMPED; grad_f = '0;
        end
        axis_data = {grad_f, style_f, ext_f, ik_f, r_pos, r_idx, r_bank};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axes <= '0; r_len <= '0; r_dead <= 1'b0; r_phase <= acsp_pkg::PH_FIRST;
            r_bank <= '0; r_idx <= '0; r_pos <= '0; r_pcnt <= '0; r_letter <= 1'b0;
            r_ik <= acsp_pkg::IK_SHORT; r_pacc <= '0; r_gacc <= '0; r_sgn <= 1'b0;
            r_neg <= 1'b0; r_dig <= 1'b0; r_ein <= 1'b0; r_eout <= 1'b0;
            r_hasg <= 1'b0; r_sp <= '0;
            r_ovalid <= 1'b0; r_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) r_axes <= i_cfg_data;
            r_len <= n_len; r_dead <= n_dead; r_phase <= n_phase; r_bank <= n_bank;
            r_idx <= n_idx; r_pos <= n_pos; r_pcnt <= n_pcnt; r_letter <= n_letter;
            r_ik <= n_ik; r_pacc <= n_pacc; r_gacc <= n_gacc; r_sgn <= n_sgn;
            r_neg <= n_neg; r_dig <= n_dig; r_ein <= n_ein; r_eout <= n_eout;
            r_hasg <= n_hasg; r_sp <= n_sp;
            if (tok_end && (axis_ok || stop_ok)) begin
                r_ovalid <= 1'b1;
                r_pend   <= is_exec;
                r_okind  <= stop_ok ? acsp_pkg::KIND_STOP : acsp_pkg::KIND_AXIS;
                r_odata  <= stop_ok ? '0 : axis_data;
                r_olast  <= !is_exec;
            end else if (in_fire && is_exec) begin
                r_ovalid <= 1'b1;
                r_pend   <= 1'b0;
                r_okind  <= acsp_pkg::KIND_EXEC;
                r_odata  <= '0;
                r_olast  <= 1'b1;
            end else if (out_fire && r_pend) begin
                r_pend   <= 1'b0;
                r_okind  <= acsp_pkg::KIND_EXEC;
                r_odata  <= '0;
                r_olast  <= 1'b1;
            end else if (out_fire) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ----- tb/axis_command_stream_parser_chk.sv -----
// ----------------------------------------------------------------------------
// axis_command_stream_parser_chk
// Watches the byte, command and config channels, keeps its own copy of the
// token buffer and axis register, predicts the command words for every
// accepted byte and compares them in order against the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_command_stream_parser_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [87:0] i_m_axis_tdata,
    input  logic [1:0]  i_m_axis_tuser,
    input  logic        i_m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [39:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int TOKEN_LIMIT = 47;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  bank;
        logic [3:0]  index;
        logic [13:0] position;
        logic [1:0]  input_kind;
        logic [30:0] ext_param;
        logic [2:0]  move_style;
        logic [31:0] gradient;
        logic        last;
    } t_cmd_word;

    t_cmd_word   cmd_expected[$];
    logic [39:0] axes_reg;
    logic [7:0]  token_buf[TOKEN_LIMIT];
    int          token_len;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = cmd_expected.size();

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // optional blanks and sign, then digits; magnitude saturates at 2^31
    function automatic bit scan_number(int p, int n, output longint val, output int stop);
        bit             neg;
        longint unsigned mag;
        int             q;
        int             first;
        neg  = 0;
        mag  = 0;
        q    = p;
        val  = 0;
        stop = p;
        while (q < n && is_blank(token_buf[q])) q++;
        if (q < n && (token_buf[q] == "+" || token_buf[q] == "-")) begin
            neg = token_buf[q] == "-";
            q++;
        end
        first = q;
        while (q < n && is_num(token_buf[q])) begin
            mag = mag * 10 + (token_buf[q] - "0");
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            q++;
        end
        if (q == first) return 0;
        if (neg) val = -longint'(mag);
        else val = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(mag);
        stop = q;
        return 1;
    endfunction

    function automatic t_cmd_word blank_word(logic [1:0] kind);
        t_cmd_word w;
        w = '0;
        w.kind = kind;
        return w;
    endfunction

    function automatic void decode_token();
        int          n;
        int          i;
        int          e;
        logic [7:0]  c;
        logic [1:0]  bank;
        logic [3:0]  idx;
        int          pos;
        logic [1:0]  ik;
        longint      ext;
        longint      grad;
        longint      v;
        bit          lead_mark;
        bit          tail_mark;
        bit          has_grad;
        t_cmd_word   w;
        n = 0;
        pos = 0;
        ik = acsp_pkg::IK_SHORT;
        ext = 0;
        grad = 0;
        lead_mark = 0;
        tail_mark = 0;
        has_grad = 0;
        while (n < token_len && token_buf[n] != 0) n++;
        if (n == 0) return;
        c = to_upper(token_buf[0]);
        if (c == "D") begin
            if (n == 5 && token_buf[0] == "D" && token_buf[1] == "S" && token_buf[2] == "T"
                && token_buf[3] == "O" && token_buf[4] == "P")
                cmd_expected.push_back(blank_word(acsp_pkg::KIND_STOP));
            return;
        end
        case (c)
            "L": bank = 2'd0;
            "R": bank = 2'd1;
            "V": bank = 2'd2;
            "A": bank = 2'd3;
            default: return;
        endcase
        if (n < 2 || !is_num(token_buf[1])) return;
        idx = 4'(token_buf[1] - "0");
        if (!axes_reg[bank * 10 + idx]) return;
        if (n < 3 || !is_num(token_buf[2])) return;
        i = 2;
        while (i < n && i < 6 && is_num(token_buf[i])) begin
            pos = pos * 10 + (token_buf[i] - "0");
            i++;
        end
        for (e = i; e < 6; e++) pos = pos * 10;
        if (i < n) begin
            c = to_upper(token_buf[i]);
            if ((c == "S" || c == "I") && scan_number(i + 1, n, v, e) && v > 0) begin
                ext = v;
                ik = (c == "S") ? acsp_pkg::IK_SPEED : acsp_pkg::IK_INTERVAL;
                i = e;
            end
        end
        while (i < n) begin
            c = to_upper(token_buf[i]);
            if (c == "<") lead_mark = 1;
            else if (c == ">") tail_mark = 1;
            else if (c == "G") break;
            i++;
        end
        if (i < n && to_upper(token_buf[i]) == "G" && scan_number(i + 1, n, v, e)) begin
            grad = v;
            has_grad = 1;
        end
        w = blank_word(acsp_pkg::KIND_AXIS);
        w.bank = bank;
        w.index = idx;
        w.position = pos[13:0];
        w.input_kind = ik;
        w.ext_param = ext[30:0];
        if (ik == acsp_pkg::IK_SHORT) begin
            w.move_style = acsp_pkg::ST_RAMPED;
            grad = 0;
        end else if (has_grad) w.move_style = acsp_pkg::ST_GRADIENT;
        else if (lead_mark && tail_mark) w.move_style = acsp_pkg::ST_EASE_BOTH;
        else if (lead_mark) w.move_style = acsp_pkg::ST_EASE_IN;
        else if (tail_mark) w.move_style = acsp_pkg::ST_EASE_OUT;
        else begin
            w.move_style = acsp_pkg::ST_RAMPED;
            grad = 0;
        end
        w.gradient = grad[31:0];
        cmd_expected.push_back(w);
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int prior_count;
        prior_count = cmd_expected.size();
        if (b == " " || b == 8'h0A || b == 8'h0D) begin
            if (token_len > 0) begin
                decode_token();
                token_len = 0;
            end
            if (b != " ") cmd_expected.push_back(blank_word(acsp_pkg::KIND_EXEC));
            if (cmd_expected.size() > prior_count) cmd_expected[$].last = 1'b1;
        end else if (token_len < TOKEN_LIMIT) begin
            token_buf[token_len] = b;
            token_len++;
        end
    endfunction

    function automatic void compare_word();
        t_cmd_word got;
        t_cmd_word exp_w;
        got.kind       = i_m_axis_tuser;
        got.bank       = i_m_axis_tdata[1:0];
        got.index      = i_m_axis_tdata[5:2];
        got.position   = i_m_axis_tdata[19:6];
        got.input_kind = i_m_axis_tdata[21:20];
        got.ext_param  = i_m_axis_tdata[52:22];
        got.move_style = i_m_axis_tdata[55:53];
        got.gradient   = i_m_axis_tdata[87:56];
        got.last       = i_m_axis_tlast;
        if (cmd_expected.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected word: %p", got);
            return;
        end
        exp_w = cmd_expected.pop_front();
        if (got !== exp_w || i_m_axis_tdata[87:56] !== exp_w.gradient) begin
            fails++;
            if (fails <= 10) $display("word mismatch: expected %p, got %p", exp_w, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            axes_reg  = '0;
            token_len = 0;
            cmd_expected.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) compare_word();
            if (i_cfg_valid && i_cfg_ready) axes_reg = i_cfg_data;
            if (i_s_axis_tvalid && i_s_axis_tready) take_byte(i_s_axis_tdata);
        end
    end

    initial fails = 0;

endmodule

// ----- tb/axis_command_stream_parser_tb.sv -----
// ----------------------------------------------------------------------------
// axis_command_stream_parser_tb
// Drives directed and random command text into the parser under several axis
// registrations, with random gaps and output stalls, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_command_stream_parser_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        m_valid;
    logic        m_ready;
    logic [87:0] m_data;
    logic [1:0]  m_user;
    logic        m_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [39:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          quiet_mode;
    bit          long_hold_req;
    logic [7:0]  text_q[$];

    axis_command_stream_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    axis_command_stream_parser_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .i_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 0;
                m_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge i_clk);
                m_ready <= 1'b1;
            end else if (quiet_mode) m_ready <= 1'b1;
            else begin
                hold = gap_len();
                if (hold == 0) m_ready <= 1'b1;
                else begin
                    m_ready <= 1'b0;
                    repeat (hold - 1) @(posedge i_clk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000) begin
            $display("axis_command_stream_parser_tb: errors");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic flush_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    task automatic send_str(string s);
        foreach (s[k]) text_q.push_back(s[k]);
        flush_text();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_axes(logic [39:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_digits(int n);
        repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic void add_number();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) text_q.push_back(8'h09);
        else if (r == 1) text_q.push_back($urandom_range(0, 1) ? 8'h0B : 8'h0C);
        r = $urandom_range(0, 9);
        if (r < 2) text_q.push_back("-");
        else if (r < 3) text_q.push_back("+");
        r = $urandom_range(0, 19);
        if (r == 0) add_digits(0);
        else if (r < 3) add_digits($urandom_range(10, 13));
        else add_digits($urandom_range(1, 5));
    endfunction

    function automatic void add_token();
        string letters;
        string word;
        int    r;
        letters = "LRVAlrva";
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 15) begin
            repeat ($urandom_range(44, 60)) text_q.push_back(8'($urandom_range(33, 126)));
        end else if (r < 20) begin
            case ($urandom_range(0, 3))
                0: word = "DSTOP";
                1: word = "dstop";
                2: word = "DSTOPX";
                default: word = "D1";
            endcase
            foreach (word[k]) text_q.push_back(word[k]);
        end else begin
            text_q.push_back(letters[$urandom_range(0, 7)]);
            if ($urandom_range(0, 19) == 0) text_q.push_back("x");
            else text_q.push_back(8'("0" + $urandom_range(0, 9)));
            add_digits($urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 5));
            if ($urandom_range(0, 3) != 0) begin
                text_q.push_back($urandom_range(0, 1) ? "S" : "i");
                add_number();
            end
            if ($urandom_range(0, 2) == 0) text_q.push_back("<");
            if ($urandom_range(0, 2) == 0) text_q.push_back(">");
            if ($urandom_range(0, 3) == 0) begin
                text_q.push_back($urandom_range(0, 1) ? "G" : "g");
                add_number();
            end
            if ($urandom_range(0, 29) == 0) text_q.push_back(8'h00);
        end
        case ($urandom_range(0, 5))
            0: text_q.push_back(8'h0D);
            1: text_q.push_back(8'h0A);
            default: text_q.push_back(" ");
        endcase
    endfunction

    task automatic random_bytes(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            add_token();
            sent += text_q.size();
            flush_text();
        end
    endtask

    initial begin
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        idle_cycles   = 0;
        quiet_mode    = 0;
        long_hold_req = 0;
        i_rst_n       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_axes({40{1'b1}});
        send_str("L0 L09999S100<>G-5\nDSTOP\rdstop a9 1I0<G5 ");
        send_str("V312S+2147483648>\nR7\t1S\t7< L1");
        text_q.push_back(8'h00);
        text_q.push_back("5");
        text_q.push_back(" ");
        text_q.push_back(8'h00);
        text_q.push_back("L");
        text_q.push_back("1");
        text_q.push_back(" ");
        text_q.push_back(8'hFF);
        flush_text();
        send_str("X1234 A5123I-2147483649G-2147483649 \r  LA12 L");
        send_str("1234567890123456789012345678901234567890123456789012\n");

        write_axes('0);
        random_bytes(150);
        write_axes(40'({$urandom, $urandom}));
        quiet_mode = 1;
        random_bytes(60);
        quiet_mode = 0;
        long_hold_req = 1;
        random_bytes(300);
        wait_drained();
        write_axes(40'({$urandom, $urandom}));
        random_bytes(300);
        write_axes({40{1'b1}});
        random_bytes(300);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("axis_command_stream_parser_tb: clean");
        else
            $display("axis_command_stream_parser_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/acsp_pkg.sv
design/axis_command_stream_parser.sv
tb/axis_command_stream_parser_chk.sv
tb/axis_command_stream_parser_tb.sv
